/* hw/rtl/smpd_pkg.sv */
// Shared types and constants for the serial mouse packet decoder.
// No dependencies; imported by smpd_core and serial_mouse_packet_decoder_top.
`timescale 1ns / 1ps

package smpd_pkg;

	// Default width of the position accumulators
	localparam int POS_WIDTH_DEF = 16;

	// protocol_mode codes
	localparam logic [1:0] MODE_THREE  = 2'd0;	// 3-byte, bit 6 sync
	localparam logic [1:0] MODE_MIDDLE = 2'd1;	// 3-byte plus middle-button byte
	localparam logic [1:0] MODE_FIVE   = 2'd2;	// 5-byte, 1000_0xxx sync

	localparam int MODE_W = 2;

	// Packet buffer
	localparam int PB_DEPTH = 5;
	localparam int PB_IDX_W = 3;

	// 5-byte sync pattern on the top five bits
	localparam logic [4:0] SYNC5_PATTERN = 5'b10000;

	// Output word layout
	localparam int OUT_DATA_W = 88;
	localparam int OUT_USED_W = 84;

	// Result of one byte, state after the byte
	typedef struct packed {
		logic              done;
		logic        [7:0] dx;
		logic        [7:0] dy;
		logic       [15:0] win_x;
		logic       [15:0] win_y;
		logic       [15:0] pos_x;
		logic       [15:0] pos_y;
		logic        [2:0] buttons;
		logic              sync;
	} smpd_result_t;

endpackage

/* hw/rtl/smpd_core.sv */
// Framing state and per-byte decode for the serial mouse packet decoder.
// Depends on smpd_pkg; instantiated by serial_mouse_packet_decoder_top.
`timescale 1ns / 1ps

module smpd_core import smpd_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,		// byte is consumed this cycle
	input  logic          [7:0] rx_byte,
	input  logic                clear_window,
	input  logic [MODE_W-1:0]   mode,
	output smpd_result_t        result		// state after this byte
);

	logic          [7:0] pb_q [PB_DEPTH];
	logic [PB_IDX_W-1:0] count_q;
	logic                sync_q;
	logic          [2:0] held_q;
	logic signed [POS_WIDTH-1:0] pos_x_q, pos_y_q;
	logic         [15:0] win_x_q, win_y_q;

	logic [PB_IDX_W-1:0] count_n;
	logic                sync_n;
	logic          [2:0] held_n;
	logic                wr_en;
	logic                done;
	logic          [7:0] dx, dy;
	logic          [7:0] pb4;
	logic          [7:0] sum_y5;
	logic [PB_IDX_W-1:0] count_p1;
	logic                fourth;
	logic         [15:0] win_x_n, win_y_n;
	logic signed [POS_WIDTH-1:0] pos_x_n, pos_y_n;

	assign count_p1 = count_q + 3'd1;
	assign fourth   = (mode == MODE_MIDDLE);
	// last byte of a 5-byte packet goes straight in without waiting for the buffer
	assign pb4      = (count_q == 3'd4) ? rx_byte : pb_q[4];
	assign sum_y5   = pb_q[2] + pb4;

	always_comb begin
		count_n = count_q;
		sync_n  = sync_q;
		held_n  = held_q;
		wr_en   = 1'b0;
		done    = 1'b0;
		dx      = 8'd0;
		dy      = 8'd0;
		unique case (mode)
			MODE_THREE, MODE_MIDDLE: begin
				if (rx_byte[6]) begin
					wr_en   = 1'b1;
					count_n = 3'd1;
					sync_n  = 1'b1;
				end else if (count_q == 3'd0) begin
					// idle, no sync: drop
				end else if (count_q >= 3'd3) begin
					if (fourth)
						held_n = {rx_byte[5], held_q[1:0]};
					count_n = 3'd0;
					sync_n  = 1'b0;
				end else begin
					wr_en   = 1'b1;
					count_n = count_p1;
					if (count_q == 3'd2) begin
						done    = 1'b1;
						dx      = {pb_q[0][1:0], pb_q[1][5:0]};
						dy      = {pb_q[0][3:2], rx_byte[5:0]};
						held_n  = {fourth & held_q[2], pb_q[0][4], pb_q[0][5]};
						count_n = fourth ? 3'd3 : 3'd0;
						sync_n  = fourth;
					end
				end
			end
			MODE_FIVE: begin
				if (rx_byte[7:3] == SYNC5_PATTERN) begin
					wr_en   = 1'b1;
					count_n = 3'd1;
					sync_n  = 1'b1;
				end else if (count_q != 3'd0) begin
					if (count_q < 3'd5) begin
						wr_en   = 1'b1;
						count_n = count_p1;
					end
					if (count_n == 3'd5) begin
						done    = 1'b1;
						dx      = pb_q[1] + pb_q[3];
						dy      = 8'd0 - sum_y5;
						held_n  = {~pb_q[0][1], ~pb_q[0][0], ~pb_q[0][2]};
						count_n = 3'd0;
						sync_n  = 1'b0;
					end else if (count_n > 3'd5) begin
						count_n = 3'd0;
						sync_n  = 1'b0;
					end
				end
			end
			default: begin
				// unused mode: bytes ignored
			end
		endcase
	end

	// dx/dy are zero when no packet completes, so the adds are unconditional
	assign win_x_n = (clear_window ? 16'd0 : win_x_q) + 16'(signed'(dx));
	assign win_y_n = (clear_window ? 16'd0 : win_y_q) + 16'(signed'(dy));
	assign pos_x_n = pos_x_q + POS_WIDTH'(signed'(dx));
	assign pos_y_n = pos_y_q + POS_WIDTH'(signed'(dy));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sync_q  <= 1'b0;
			held_q  <= '0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			win_x_q <= '0;
			win_y_q <= '0;
		end else if (step) begin
			count_q <= count_n;
			sync_q  <= sync_n;
			held_q  <= held_n;
			pos_x_q <= pos_x_n;
			pos_y_q <= pos_y_n;
			win_x_q <= win_x_n;
			win_y_q <= win_y_n;
		end
	end

	// packet buffer, no reset; a sync byte always lands in entry 0
	always_ff @(posedge clk) begin
		if (step && wr_en && (count_n == 3'd1 || count_q < 3'(PB_DEPTH)))
			pb_q[(count_n == 3'd1) ? 3'd0 : count_q] <= rx_byte;
	end

	always_comb begin
		result.done    = done;
		result.dx      = dx;
		result.dy      = dy;
		result.win_x   = win_x_n;
		result.win_y   = win_y_n;
		result.pos_x   = 16'(pos_x_n);
		result.pos_y   = 16'(pos_y_n);
		result.buttons = held_n;
		result.sync    = sync_n;
	end

	// sync is set exactly while part of a packet is held
	a_sync_count: assert property (@(posedge clk) disable iff (!arst_n)
		sync_q == (count_q != 3'd0))
		else $error("sync flag and byte count disagree");

	// a completed packet leaves the count at zero, or at three awaiting the middle byte
	a_done_count: assert property (@(posedge clk) disable iff (!arst_n)
		step && done |=> (count_q == 3'd0) || (count_q == 3'd3))
		else $error("bad byte count after packet");

	// a full 5-byte packet is consumed on its last byte, so the count never passes four
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("byte count out of range");

endmodule

/* hw/rtl/serial_mouse_packet_decoder_top.sv */
// Top level of the serial mouse packet decoder: stream ports, mode register,
// input and result registers. Depends on smpd_pkg and smpd_core.
`timescale 1ns / 1ps

// Serial mouse packet decoder. Feed it the received mouse bytes as words on
// s_axis; every word gives exactly one result word on m_axis, in order,
// showing the decoder state after that byte: the deltas of a packet that the
// byte completed (packet_done in tuser, deltas zero otherwise), the window
// sums, the wrapping position, buttons and the sync flag. protocol_mode
// (cfg_data[1:0]) picks 3-byte bit-6 sync (0), 3-byte plus optional middle
// button byte (1), or 5-byte 0x80 sync with summed deltas (2); code 3
// ignores bytes and only honors clear_window. Write the mode only while no
// word is in flight. Throughput is one byte per clock while the result side
// does not stall: the framing state is updated by a single pass of logic
// between the input register and the result register, and a word waiting in
// the result register does not stop the next byte entering an empty input
// register. Each byte passes through the input register, then the result
// register, and waits in the input register only while the result side
// stalls. No clearing pass is needed after reset.

module serial_mouse_packet_decoder_top import smpd_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF	// position accumulator width, 8..32
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [MODE_W-1:0]     cfg_data,		// protocol_mode

	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic            [7:0] s_axis_tdata,	// [7:0] rx_byte
	input  logic            [0:0] s_axis_tuser,	// [0] clear_window

	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [7:0] delta_x, [15:8] delta_y, [31:16] window_dx, [47:32] window_dy,
	// [63:48] pos_x, [79:64] pos_y, [82:80] button_bits, [83] in_sync, rest zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic            [0:0] m_axis_tuser	// [0] packet_done
);

	logic [MODE_W-1:0] mode_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       clear_s1;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_done_q;

	logic         in_accept;
	logic         advance;
	smpd_result_t res;

	// mode register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= MODE_THREE;
		else if (cfg_valid)
			mode_q <= cfg_data;
	end

	// byte in the input register moves on when the result register is free or emptying
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_accept)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1  <= s_axis_tdata;
			clear_s1 <= s_axis_tuser[0];
		end
	end

	smpd_core #(
		.POS_WIDTH(POS_WIDTH)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.rx_byte     (byte_s1),
		.clear_window(clear_s1),
		.mode        (mode_q),
		.result      (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_done_q <= res.done;
			out_data_q <= {(OUT_DATA_W - OUT_USED_W)'(0), res.sync, res.buttons,
				res.pos_y, res.pos_x, res.win_y, res.win_x, res.dy, res.dx};
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_data_q;
	assign m_axis_tuser[0] = out_done_q;

	// input side stalls only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

	// a taken result with nothing behind it empties the result register
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !valid_s1 |=> !m_axis_tvalid)
		else $error("result repeated");

	// no completed packet means zero deltas
	a_zero_delta: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !res.done |=> m_axis_tdata[15:0] == 16'd0)
		else $error("nonzero delta without packet");

endmodule
